FILE: hdl/lpb_pkg.sv
// ----------------------------------------------------------------------------
// lpb_pkg: shared types and constants of the LED pixel buffer engine
// Pixel layout, command codes, mix-mode bits, store port bundle and the
// reciprocal used by the brightness scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package lpb_pkg;

  // Pixel store geometry
  localparam int LED_MAX = 1024;
  localparam int IDX_W   = $clog2(LED_MAX);
  localparam int CNT_W   = 11;             // count and strip_length width
  localparam int POS_W   = 16;
  localparam int CH_W    = 8;
  localparam int NCH     = 3;

  localparam logic [CNT_W-1:0] LED_MAX_C = CNT_W'(LED_MAX);

  // Channel lanes inside a pixel
  localparam int CH_R = 0;
  localparam int CH_G = 1;
  localparam int CH_B = 2;

  // Mix-mode bits, in priority order
  localparam int MIX_OR_BIT   = 0;
  localparam int MIX_XOR_BIT  = 1;
  localparam int MIX_OVER_BIT = 2;
  localparam logic [NCH-1:0] MIX_OVER_M = NCH'(1) << MIX_OVER_BIT;
  localparam logic [NCH-1:0] CH_ALL_M   = '1;

  // value*brightness/100 == (p * 83887) >> 23 for every p up to 255*255
  localparam int              SCALE_SHIFT = 23;
  localparam int              RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] SCALE_RECIP = RECIP_W'(83887);
  localparam int              PROD_W      = 2 * CH_W;
  localparam int              WIDE_W      = PROD_W + RECIP_W;

  typedef logic [NCH-1:0][CH_W-1:0] pixel_t;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_READ     = 3'd1,
    CMD_FILL     = 3'd2,
    CMD_ROT_FWD  = 3'd3,
    CMD_ROT_BACK = 3'd4,
    CMD_FADE     = 3'd5
  } cmd_e;

  // One read and one write port request toward the pixel store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pixel_t           wr_data;
  } store_req_t;

endpackage

`default_nettype wire

FILE: hdl/lpb_store.sv
// ----------------------------------------------------------------------------
// lpb_store: pixel memory
// One write port and one read port per cycle, registered read data that
// holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_store
  import lpb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire store_req_t req_i,
  output pixel_t          rd_data_o
);

  pixel_t mem [LED_MAX];
  pixel_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: hdl/lpb_scale.sv
// ----------------------------------------------------------------------------
// lpb_scale: brightness scaler
// Two-stage unit: multiply each channel by brightness, then divide by 100
// through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_scale
  import lpb_pkg::*;
(
  input  wire logic            clk_i,
  input  wire pixel_t          pix_i,
  input  wire logic [CH_W-1:0] bright_i,
  output pixel_t               pix_o
);

  logic [NCH-1:0][PROD_W-1:0] prod_q;
  logic [NCH-1:0][WIDE_W-1:0] wide;
  pixel_t                     quot_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCH; c++) begin
      prod_q[c] <= PROD_W'(pix_i[c]) * PROD_W'(bright_i);
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      wide[c] = WIDE_W'(prod_q[c]) * WIDE_W'(SCALE_RECIP);
    end
  end

  // keep the low byte of the quotient
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCH; c++) begin
      quot_q[c] <= wide[c][SCALE_SHIFT +: CH_W];
    end
  end

  assign pix_o = quot_q;

endmodule

`default_nettype wire

FILE: hdl/led_pixel_buffer_engine.sv
// ----------------------------------------------------------------------------
// led_pixel_buffer_engine: RGB pixel store with raster commands
// Sequencer around one pixel memory and one shared brightness scaler.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-pixel store to zero, one pixel per
// cycle, and keeps in_stall_o high for the whole sweep; strip_length writes
// are taken meanwhile. It then works on one command at a time and stalls its
// input until the command is done. Per command: an on-strip read issues one
// store read, then waits for the output register, longer while an earlier
// read beat still waits there under stall (the read beat then sits in the
// output register, so a later command can start while it waits to be taken);
// write and fade take each pixel through read, two scaler stages and write
// back; fill waits out the scaler stages once, then writes each pixel that
// lands on the strip; rotate saves the wrapping pixel, does one memory read
// then one write per step, then writes the saved pixel back. Unused command
// codes, writes to off-strip positions, fills that land no pixel on the
// strip, fades of length zero and rotates of length below two never leave
// the idle state. The store's single read and write port set these steps.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pixel_buffer_engine
  import lpb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration: strip_length
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CNT_W-1:0] cfg_data_i,
  // command beats
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [2:0]       cmd_i,
  input  wire logic [POS_W-1:0] position_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic [CH_W-1:0]  red_i,
  input  wire logic [CH_W-1:0]  green_i,
  input  wire logic [CH_W-1:0]  blue_i,
  input  wire logic [CH_W-1:0]  brightness_i,
  input  wire logic [NCH-1:0]   channel_enable_i,
  input  wire logic [NCH-1:0]   mix_select_i,
  // read result beats
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [CH_W-1:0]       read_red_o,
  output logic [CH_W-1:0]       read_green_o,
  output logic [CH_W-1:0]       read_blue_o,
  output logic                  in_range_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_DONE,
    ST_PX_RD,
    ST_PX_S0,
    ST_PX_S1,
    ST_PX_WR,
    ST_FILL_S1,
    ST_FILL_S2,
    ST_FILL,
    ST_ROT_SAVE,
    ST_ROT_TMP,
    ST_ROT_RD,
    ST_ROT_WR,
    ST_ROT_LAST
  } state_e;

  // Apply one pixel's mix: OR over XOR over overwrite, enabled lanes only.
  function automatic pixel_t mix_pix(pixel_t dst, pixel_t val,
                                     logic [NCH-1:0] chans, logic [NCH-1:0] mode);
    pixel_t         res;
    logic [NCH-1:0] ch;
    logic [NCH-1:0] md;
    res = dst;
    ch  = chans;
    md  = mode;
    // empty lane and mode masks mean overwrite all lanes
    if (ch == '0 && md == '0) begin
      ch = CH_ALL_M;
      md = MIX_OVER_M;
    end
    for (int c = 0; c < NCH; c++) begin
      if (ch[c]) begin
        if (md[MIX_OR_BIT]) begin
          res[c] = dst[c] | val[c];
        end else if (md[MIX_XOR_BIT]) begin
          res[c] = dst[c] ^ val[c];
        end else if (md[MIX_OVER_BIT]) begin
          res[c] = val[c];
        end
      end
    end
    return res;
  endfunction

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  strip_q, strip_d;
  logic [CNT_W-1:0]  idx_q, idx_d;      // current pixel / rotate destination
  logic [CNT_W-1:0]  end_q, end_d;      // one past the last pixel of a run
  logic [CNT_W-1:0]  rem_q, rem_d;      // rotate moves left
  logic [IDX_W-1:0]  nm1_q, nm1_d;      // last pixel of the rotate window
  logic              fwd_q, fwd_d;
  logic              fade_q, fade_d;
  logic              rng_q, rng_d;
  pixel_t            color_q, color_d;
  pixel_t            tmp_q, tmp_d;
  logic [CH_W-1:0]   bright_q, bright_d;
  logic [NCH-1:0]    chans_q, chans_d;
  logic [NCH-1:0]    mode_q, mode_d;
  logic              out_valid_q, out_valid_d;
  pixel_t            out_pix_q, out_pix_d;
  logic              out_rng_q, out_rng_d;

  store_req_t        req;
  pixel_t            rd_data;
  pixel_t            scale_in;
  pixel_t            scaled;

  logic              in_take;
  logic              out_free;
  logic [CNT_W-1:0]  alen;
  logic [CNT_W-1:0]  n_c;
  logic              pos_ok;
  logic signed [POS_W+1:0] sum_c;
  logic [CNT_W-1:0]  fill_start;
  logic [CNT_W-1:0]  fill_end;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;
  logic [IDX_W-1:0]  rot_src;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;

  // Active strip length, command length and range checks on the incoming beat
  assign alen   = (strip_q > LED_MAX_C) ? LED_MAX_C : strip_q;
  assign n_c    = (count_i > alen) ? alen : count_i;
  assign pos_ok = !position_i[POS_W-1] && (position_i < POS_W'(alen));
  assign sum_c  = (POS_W+2)'($signed(position_i)) + $signed({7'b0, count_i});

  always_comb begin
    if (position_i[POS_W-1]) begin
      fill_start = '0;
    end else if (pos_ok) begin
      fill_start = position_i[CNT_W-1:0];
    end else begin
      fill_start = alen;
    end
    if (sum_c <= 0) begin
      fill_end = '0;
    end else if (sum_c > $signed((POS_W+2)'(alen))) begin
      fill_end = alen;
    end else begin
      fill_end = sum_c[CNT_W-1:0];
    end
  end

  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);
  assign rot_src = fwd_q ? idx_dec[IDX_W-1:0] : idx_inc[IDX_W-1:0];

  // Fade scales the stored pixel, write and fill scale the command color
  assign scale_in = fade_q ? rd_data : color_q;

  lpb_scale u_scale (
    .clk_i    (clk_i),
    .pix_i    (scale_in),
    .bright_i (bright_q),
    .pix_o    (scaled)
  );

  lpb_store u_store (
    .clk_i     (clk_i),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    strip_d     = strip_q;
    idx_d       = idx_q;
    end_d       = end_q;
    rem_d       = rem_q;
    nm1_d       = nm1_q;
    fwd_d       = fwd_q;
    fade_d      = fade_q;
    rng_d       = rng_q;
    color_d     = color_q;
    tmp_d       = tmp_q;
    bright_d    = bright_q;
    chans_d     = chans_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_rng_d   = out_rng_q;
    req         = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      strip_d = cfg_data_i;
    end

    // drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_q[IDX_W-1:0];
        req.wr_data = '0;
        idx_d       = idx_inc;
        if (idx_q == CNT_W'(LED_MAX - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_take) begin
          color_d[CH_R] = red_i;
          color_d[CH_G] = green_i;
          color_d[CH_B] = blue_i;
          bright_d      = brightness_i;
          chans_d       = channel_enable_i;
          mode_d        = mix_select_i;
          fade_d        = 1'b0;
          unique case (cmd_i) inside
            CMD_WRITE: begin
              idx_d = position_i[CNT_W-1:0];
              end_d = position_i[CNT_W-1:0] + CNT_W'(1);
              if (pos_ok) begin
                state_d = ST_PX_RD;
              end
            end
            CMD_READ: begin
              idx_d   = position_i[CNT_W-1:0];
              rng_d   = pos_ok;
              state_d = pos_ok ? ST_RD_ISSUE : ST_RD_DONE;
            end
            CMD_FILL: begin
              idx_d = fill_start;
              end_d = fill_end;
              if (fill_start < fill_end) begin
                state_d = ST_FILL_S1;
              end
            end
            CMD_ROT_FWD, CMD_ROT_BACK: begin
              fwd_d = (cmd_i == CMD_ROT_FWD);
              nm1_d = IDX_W'(n_c - CNT_W'(1));
              rem_d = n_c - CNT_W'(1);
              idx_d = (cmd_i == CMD_ROT_FWD) ? (n_c - CNT_W'(1)) : '0;
              if (n_c > CNT_W'(1)) begin
                state_d = ST_ROT_SAVE;
              end
            end
            CMD_FADE: begin
              fade_d = 1'b1;
              idx_d  = '0;
              end_d  = n_c;
              if (n_c != '0) begin
                state_d = ST_PX_RD;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_RD_ISSUE: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx_q[IDX_W-1:0];
        state_d     = ST_RD_DONE;
      end

      // hold the read data until the output register frees up
      ST_RD_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = rng_q ? rd_data : '0;
          out_rng_d   = rng_q;
          state_d     = ST_IDLE;
        end
      end

      ST_PX_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = idx_q[IDX_W-1:0];
        state_d     = ST_PX_S0;
      end

      ST_PX_S0: begin
        state_d = ST_PX_S1;
      end

      ST_PX_S1: begin
        state_d = ST_PX_WR;
      end

      ST_PX_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_q[IDX_W-1:0];
        req.wr_data = mix_pix(rd_data, scaled, chans_q, mode_q);
        idx_d       = idx_inc;
        state_d     = (idx_inc == end_q) ? ST_IDLE : ST_PX_RD;
      end

      ST_FILL_S1: begin
        state_d = ST_FILL_S2;
      end

      ST_FILL_S2: begin
        state_d = ST_FILL;
      end

      ST_FILL: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_q[IDX_W-1:0];
        req.wr_data = scaled;
        idx_d       = idx_inc;
        if (idx_inc == end_q) begin
          state_d = ST_IDLE;
        end
      end

      // save the pixel that wraps around the window
      ST_ROT_SAVE: begin
        req.rd_en   = 1'b1;
        req.rd_addr = fwd_q ? nm1_q : '0;
        state_d     = ST_ROT_TMP;
      end

      ST_ROT_TMP: begin
        tmp_d   = rd_data;
        state_d = ST_ROT_RD;
      end

      ST_ROT_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = rot_src;
        state_d     = ST_ROT_WR;
      end

      ST_ROT_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = idx_q[IDX_W-1:0];
        req.wr_data = rd_data;
        idx_d       = fwd_q ? idx_dec : idx_inc;
        rem_d       = rem_q - CNT_W'(1);
        state_d     = (rem_q == CNT_W'(1)) ? ST_ROT_LAST : ST_ROT_RD;
      end

      ST_ROT_LAST: begin
        req.wr_en   = 1'b1;
        req.wr_addr = fwd_q ? '0 : nm1_q;
        req.wr_data = tmp_q;
        state_d     = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      strip_q     <= LED_MAX_C;
      idx_q       <= '0;
      end_q       <= '0;
      rem_q       <= '0;
      nm1_q       <= '0;
      fwd_q       <= 1'b0;
      fade_q      <= 1'b0;
      rng_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      strip_q     <= strip_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      rem_q       <= rem_d;
      nm1_q       <= nm1_d;
      fwd_q       <= fwd_d;
      fade_q      <= fade_d;
      rng_q       <= rng_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    color_q   <= color_d;
    tmp_q     <= tmp_d;
    bright_q  <= bright_d;
    chans_q   <= chans_d;
    mode_q    <= mode_d;
    out_pix_q <= out_pix_d;
    out_rng_q <= out_rng_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_red_o   = out_pix_q[CH_R];
  assign read_green_o = out_pix_q[CH_G];
  assign read_blue_o  = out_pix_q[CH_B];
  assign in_range_o   = out_rng_q;

endmodule

`default_nettype wire

FILE: hdl/lpb_checker.sv
// ----------------------------------------------------------------------------
// lpb_checker: port-level checks for the LED pixel buffer engine
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_checker
  import lpb_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [2:0]       cmd_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [CH_W-1:0]  read_red_o,
  input wire logic [CH_W-1:0]  read_green_o,
  input wire logic [CH_W-1:0]  read_blue_o,
  input wire logic             in_range_o
);

  // reset holds the block in its store clear state, so no beat can be taken
  a_stall_in_reset: assert property (@(posedge clk_i) !rst_ni |-> in_stall_o)
    else $error("input not stalled during reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_red_o) &&
      $stable(read_green_o) && $stable(read_blue_o) && $stable(in_range_o))
    else $error("stalled result beat changed");

  // off-strip reads return black
  a_off_strip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |->
      read_red_o == '0 && read_green_o == '0 && read_blue_o == '0)
    else $error("off-strip read returned nonzero color");

  // an accepted read beat is followed by a stalled input
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_READ |=> in_stall_o)
    else $error("input free right after a read beat");

endmodule

bind led_pixel_buffer_engine lpb_checker u_lpb_checker (.*);

`default_nettype wire

FILE: verif/tb_led_pixel_buffer_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_pixel_buffer_engine: self-checking bench for the LED pixel buffer
// Keeps a shadow copy of the pixel store and strip length, updates it on
// every accepted command beat and checks each read beat against it. Directed
// tests cover the corner cases, then random traffic runs over several strip
// lengths with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------

module tb_led_pixel_buffer_engine;
  import lpb_pkg::*;

  // Command codes with no enum member: the block must ignore them
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Channel and mix masks
  localparam logic [NCH-1:0] MASK_NONE = '0;
  localparam logic [NCH-1:0] CH_RED_M  = NCH'(1) << CH_R;
  localparam logic [NCH-1:0] MIX_OR_M  = NCH'(1) << MIX_OR_BIT;
  localparam logic [NCH-1:0] MIX_XOR_M = NCH'(1) << MIX_XOR_BIT;

  // Wait this long for a full-strip fade to finish before touching the register
  // or ending the run
  localparam int SETTLE_CYCLES   = 4200;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES      = 7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct {
    logic [2:0]       cmd;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  brightness;
    logic [NCH-1:0]   chans;
    logic [NCH-1:0]   mix;
  } cmd_beat_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            in_range;
  } read_beat_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [2:0]       cmd_i;
  logic [POS_W-1:0] position_i;
  logic [CNT_W-1:0] count_i;
  logic [CH_W-1:0]  red_i;
  logic [CH_W-1:0]  green_i;
  logic [CH_W-1:0]  blue_i;
  logic [CH_W-1:0]  brightness_i;
  logic [NCH-1:0]   channel_enable_i;
  logic [NCH-1:0]   mix_select_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [CH_W-1:0]  read_red_o;
  logic [CH_W-1:0]  read_green_o;
  logic [CH_W-1:0]  read_blue_o;
  logic             in_range_o;

  // Shadow of the block's state
  pixel_t           frame_model [LED_MAX];
  int               strip_len_model;
  read_beat_t       pending_reads[$];

  int               mismatch_count;
  int               beats_sent;
  int               reads_checked;
  int               length_writes;
  int               burst_left;

  led_pixel_buffer_engine u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .position_i       (position_i),
    .count_i          (count_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .brightness_i     (brightness_i),
    .channel_enable_i (channel_enable_i),
    .mix_select_i     (mix_select_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .read_red_o       (read_red_o),
    .read_green_o     (read_green_o),
    .read_blue_o      (read_blue_o),
    .in_range_o       (in_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow store arithmetic
  // --------------------------------------------------------------------------

  function automatic int active_len();
    return (strip_len_model > LED_MAX) ? LED_MAX : strip_len_model;
  endfunction

  function automatic bit pixel_on_strip(int idx);
    return (idx >= 0) && (idx < active_len());
  endfunction

  // value * brightness / 100, low 8 bits kept
  function automatic logic [CH_W-1:0] scaled(logic [CH_W-1:0] v, logic [CH_W-1:0] bright);
    int unsigned prod;
    prod = int'(v) * int'(bright);
    return CH_W'(prod / 100);
  endfunction

  // OR beats XOR beats overwrite; with no mode bit the old value stays
  function automatic logic [CH_W-1:0] mixed(logic [CH_W-1:0] old_v, logic [CH_W-1:0] val,
                                            logic [NCH-1:0] mode);
    if (mode[MIX_OR_BIT])        return old_v | val;
    else if (mode[MIX_XOR_BIT])  return old_v ^ val;
    else if (mode[MIX_OVER_BIT]) return val;
    else                         return old_v;
  endfunction

  task automatic blend_pixel(int idx, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b, logic [NCH-1:0] chans,
                             logic [NCH-1:0] mode, logic [CH_W-1:0] bright);
    logic [NCH-1:0] ch;
    logic [NCH-1:0] md;
    ch = chans;
    md = mode;
    // both masks empty: overwrite all three channels
    if (ch == MASK_NONE && md == MASK_NONE) begin
      ch = CH_ALL_M;
      md = MIX_OVER_M;
    end
    if (md == MASK_NONE) return;
    if (ch[CH_R]) frame_model[idx][CH_R] = mixed(frame_model[idx][CH_R], scaled(r, bright), md);
    if (ch[CH_G]) frame_model[idx][CH_G] = mixed(frame_model[idx][CH_G], scaled(g, bright), md);
    if (ch[CH_B]) frame_model[idx][CH_B] = mixed(frame_model[idx][CH_B], scaled(b, bright), md);
  endtask

  // Update the shadow store for one accepted beat; queue the read beat it owes
  task automatic apply_command(cmd_beat_t beat);
    int         start;
    int         n;
    int         i;
    pixel_t     carry;
    read_beat_t rd;
    start = int'($signed(beat.position));
    n     = (int'(beat.count) > active_len()) ? active_len() : int'(beat.count);
    case (beat.cmd)
      CMD_WRITE: begin
        if (pixel_on_strip(start))
          blend_pixel(start, beat.red, beat.green, beat.blue, beat.chans, beat.mix,
                      beat.brightness);
      end
      CMD_READ: begin
        if (pixel_on_strip(start)) begin
          rd.red      = frame_model[start][CH_R];
          rd.green    = frame_model[start][CH_G];
          rd.blue     = frame_model[start][CH_B];
          rd.in_range = 1'b1;
        end else begin
          rd = '{default: '0};
        end
        pending_reads.push_back(rd);
      end
      CMD_FILL: begin
        // no wrap: off-strip indices are skipped
        for (i = start; i < start + int'(beat.count); i++)
          if (pixel_on_strip(i))
            blend_pixel(i, beat.red, beat.green, beat.blue, CH_ALL_M, MIX_OVER_M,
                        beat.brightness);
      end
      CMD_ROT_FWD: begin
        if (n > 1) begin
          carry = frame_model[n-1];
          for (i = n - 1; i > 0; i--) frame_model[i] = frame_model[i-1];
          frame_model[0] = carry;
        end
      end
      CMD_ROT_BACK: begin
        if (n > 1) begin
          carry = frame_model[0];
          for (i = 0; i < n - 1; i++) frame_model[i] = frame_model[i+1];
          frame_model[n-1] = carry;
        end
      end
      CMD_FADE: begin
        for (i = 0; i < n; i++)
          blend_pixel(i, frame_model[i][CH_R], frame_model[i][CH_G], frame_model[i][CH_B],
                      beat.chans, beat.mix, beat.brightness);
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Beat construction and driving
  // --------------------------------------------------------------------------

  function automatic cmd_beat_t make_beat(logic [2:0] cmd, int pos, int count, int red,
                                          int green, int blue, int bright,
                                          logic [NCH-1:0] chans, logic [NCH-1:0] mix);
    cmd_beat_t b;
    b.cmd        = cmd;
    b.position   = pos[POS_W-1:0];
    b.count      = count[CNT_W-1:0];
    b.red        = red[CH_W-1:0];
    b.green      = green[CH_W-1:0];
    b.blue       = blue[CH_W-1:0];
    b.brightness = bright[CH_W-1:0];
    b.chans      = chans;
    b.mix        = mix;
    return b;
  endfunction

  function automatic cmd_beat_t random_beat();
    cmd_beat_t b;
    int        pick;
    int        span;
    span = active_len();
    pick = $urandom_range(0, 99);
    if (pick < 30)      b.cmd = CMD_READ;
    else if (pick < 54) b.cmd = CMD_WRITE;
    else if (pick < 66) b.cmd = CMD_FILL;
    else if (pick < 76) b.cmd = CMD_ROT_FWD;
    else if (pick < 86) b.cmd = CMD_ROT_BACK;
    else if (pick < 96) b.cmd = CMD_FADE;
    else                b.cmd = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
    // mostly on the strip, a few just past either end, a few anywhere
    pick = $urandom_range(0, 99);
    if (pick < 82)      b.position = POS_W'($urandom_range(0, span + 2));
    else if (pick < 94) b.position = POS_W'(-int'($urandom_range(1, 20)));
    else                b.position = POS_W'($urandom());
    // keep most ranges short so the long walks stay rare
    pick = $urandom_range(0, 99);
    if (pick < 85)      b.count = CNT_W'($urandom_range(0, 12));
    else if (pick < 97) b.count = CNT_W'($urandom_range(0, 150));
    else                b.count = CNT_W'($urandom_range(0, LED_MAX));
    b.red   = CH_W'($urandom_range(0, 255));
    b.green = CH_W'($urandom_range(0, 255));
    b.blue  = CH_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40)      b.brightness = CH_W'(100);
    else if (pick < 48) b.brightness = '0;
    else                b.brightness = CH_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 12) begin
      b.chans = MASK_NONE;
      b.mix   = MASK_NONE;
    end else begin
      b.chans = NCH'($urandom_range(0, 7));
      b.mix   = NCH'($urandom_range(0, 7));
    end
    return b;
  endfunction

  // Present one beat at a falling edge and hold it until accepted; idle
  // for a random gap between bursts
  task automatic send_beat(cmd_beat_t beat);
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
    end
    @(negedge clk_i);
    cmd_i            <= beat.cmd;
    position_i       <= beat.position;
    count_i          <= beat.count;
    red_i            <= beat.red;
    green_i          <= beat.green;
    blue_i           <= beat.blue;
    brightness_i     <= beat.brightness;
    channel_enable_i <= beat.chans;
    mix_select_i     <= beat.mix;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    apply_command(beat);
    beats_sent++;
    burst_left--;
  endtask

  // Drop valid, wait for every owed read beat, then let a full-strip walk finish
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_strip_length(int len);
    @(negedge clk_i);
    cfg_data_i  <= CNT_W'(len);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    strip_len_model = len;
    length_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Compare every accepted read beat with the oldest one owed
  always @(posedge clk_i) begin : read_check
    read_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reads.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: read beat with none expected (r %0d g %0d b %0d in_range %0d)",
                 $time, read_red_o, read_green_o, read_blue_o, in_range_o);
      end else begin
        want = pending_reads.pop_front();
        check_field("read_red", want.red, read_red_o);
        check_field("read_green", want.green, read_green_o);
        check_field("read_blue", want.blue, read_blue_o);
        check_field("in_range", want.in_range, in_range_o);
        reads_checked++;
      end
    end
  end

  // Receiver back-pressure: switch between stall patterns, holding each for a random span
  initial begin : stall_pattern
    stall_mode_e mode;
    int          len;
    int          tick;
    out_stall_i = 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(20, 200);
      repeat (len) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 99) < 75);
          STALL_PERIODIC: out_stall_i <= ((tick % 5) < 3);
          default:        out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Write the register while the store is being swept, then read a fresh pixel
  task automatic test_reset_state();
    write_strip_length(LED_MAX);
    send_beat(make_beat(CMD_READ, LED_MAX - 1, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
  endtask

  // Both strip ends, positions just past them and the field extremes
  task automatic test_write_read();
    send_beat(make_beat(CMD_WRITE, 0, 0, 255, 0, 128, 100, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_WRITE, LED_MAX - 1, 0, 200, 255, 1, 255, CH_ALL_M, MIX_OVER_M));
    send_beat(make_beat(CMD_WRITE, LED_MAX, 0, 9, 9, 9, 100, CH_ALL_M, MIX_OVER_M));
    send_beat(make_beat(CMD_WRITE, -32768, 0, 9, 9, 9, 100, CH_ALL_M, MIX_OVER_M));
    send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_READ, LED_MAX - 1, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_READ, LED_MAX, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_READ, 32767, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
  endtask

  // Half-empty masks change nothing; OR wins over XOR, XOR over overwrite
  task automatic test_mix_modes();
    send_beat(make_beat(CMD_WRITE, 0, 0, 1, 2, 3, 100, CH_RED_M, MASK_NONE));
    send_beat(make_beat(CMD_WRITE, 0, 0, 1, 2, 3, 100, MASK_NONE, MIX_OVER_M));
    send_beat(make_beat(CMD_WRITE, 0, 0, 15, 240, 7, 100, CH_ALL_M, CH_ALL_M));
    send_beat(make_beat(CMD_WRITE, 0, 0, 0, 255, 255, 100, CH_ALL_M & ~CH_RED_M,
                        MIX_XOR_M | MIX_OVER_M));
    send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
  endtask

  // Ranges that start before the strip, run past its end, or are empty
  task automatic test_fill();
    send_beat(make_beat(CMD_FILL, -3, 8, 40, 80, 120, 100, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_FILL, LED_MAX - 4, LED_MAX, 50, 60, 70, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_FILL, 10, 0, 255, 255, 255, 100, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_READ, 2, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
  endtask

  // Whole strip, length one (no move) and the shortest real move
  task automatic test_rotate();
    send_beat(make_beat(CMD_ROT_FWD, 0, LED_MAX, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_ROT_BACK, 0, 1, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_ROT_BACK, 0, 2, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_READ, 1, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
  endtask

  task automatic test_fade();
    send_beat(make_beat(CMD_FADE, 0, LED_MAX, 0, 0, 0, 50, CH_ALL_M, MIX_OVER_M));
    send_beat(make_beat(CMD_FADE, 0, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
    send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
  endtask

  // Spare codes must leave the store alone and return nothing
  task automatic test_unused_cmds();
    send_beat(make_beat(CMD_SPARE_LO, 0, 5, 255, 255, 255, 100, CH_ALL_M, MIX_OVER_M));
    send_beat(make_beat(CMD_SPARE_HI, 1, 5, 255, 255, 255, 100, CH_ALL_M, MIX_OVER_M));
    send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, MASK_NONE, MASK_NONE));
  endtask

  // Random traffic, one phase per strip length, both extremes included
  task automatic test_random_traffic();
    int strip_plan [NUM_PHASES];
    int p;
    strip_plan = '{1, 5, 64, 300, 1000, 1023, LED_MAX};
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_strip_length(strip_plan[p]);
      repeat (ITEMS_PER_PHASE) send_beat(random_beat());
    end
  endtask

  task automatic finish_run();
    settle();
    if (pending_reads.size() != 0) begin
      mismatch_count++;
      $display("%0t ns: %0d read beats never arrived", $time, pending_reads.size());
    end
    $display("Sent %0d command beats, checked %0d read beats, %0d strip length writes.",
             beats_sent, reads_checked, length_writes);
    if (mismatch_count == 0) begin
      $display("led_pixel_buffer_engine: match");
    end else begin
      $display("led_pixel_buffer_engine: mismatch");
    end
    $finish;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin : main_seq
    int i;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    cmd_i            = '0;
    position_i       = '0;
    count_i          = '0;
    red_i            = '0;
    green_i          = '0;
    blue_i           = '0;
    brightness_i     = '0;
    channel_enable_i = '0;
    mix_select_i     = '0;
    mismatch_count   = 0;
    beats_sent       = 0;
    reads_checked    = 0;
    length_writes    = 0;
    burst_left       = 0;
    strip_len_model  = LED_MAX;
    for (i = 0; i < LED_MAX; i++) frame_model[i] = '0;

    // hold reset, then release away from the rising edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_write_read();
    test_mix_modes();
    test_fill();
    test_rotate();
    test_fade();
    test_unused_cmds();
    test_random_traffic();
    finish_run();
  end

  // Watchdog: far beyond the slowest legal run of this stimulus
  initial begin : watchdog
    #(64'd40_000_000);
    $display("Timed out with %0d read beats outstanding", pending_reads.size());
    $display("led_pixel_buffer_engine: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
hdl/lpb_pkg.sv
hdl/lpb_store.sv
hdl/lpb_scale.sv
hdl/led_pixel_buffer_engine.sv
hdl/lpb_checker.sv
verif/tb_led_pixel_buffer_engine.sv
